FILE: src/fftr_pkg.sv
// ----------------------------------------------------------------------------
// fftr_pkg: shared definitions for the in-place radix-2 FFT
// Word widths, request and register codes, the twiddle generator and the
// saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fftr_pkg;

    localparam int WORD_W          = 27;
    localparam int REQ_W           = 2;
    localparam int INDEX_W         = 10;
    localparam int LOG2_W          = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 4;
    localparam int TW_W            = 17;
    localparam int MAX_POINTS_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [LOG2_W-1:0] LOG2_LENGTH_RST = 4'd10;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    // Taylor series divisors (2n-1)*(2n) for n = 1..16.
    localparam longint unsigned TAYLOR_DIV [16] = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182, 64'd240,
        64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992
    };

    localparam logic signed [WORD_W-1:0] WORD_MAX = 27'sh3FFFFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 27'sh4000000;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOG2_LENGTH  = 2'd0,
        CFG_INVERSE_MODE = 2'd1
    } cfg_idx_t;

    // Cosine of a Q30 angle by a Taylor series, rounded to Q15 (1.0 is 32768).
    function automatic logic [TW_W-1:0] cos_q15(input longint theta);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        x2   = (unsigned'(theta) * unsigned'(theta)) >> 30;
        sum  = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
            if (n[0] == 1'b1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q < 0) begin
            q = 0;
        end
        if (q > 32768) begin
            q = 32768;
        end
        return TW_W'(q);
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [31:0] v);
        if (v > 32'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < 32'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/radix2_fft_inplace.sv
// A write or no-op result is registered in the cycle after acceptance; an in-range
// read passes through the sample memory read register and then the result register.
// A run does the bit reversal, every butterfly stage and, in inverse mode, the scaling
// pass, then loads its result. The sample memory has one read and one write port.
// Throughput: one transaction at a time; a new one is taken once the result is out.
// Reset: control and configuration are reset; the sample memory is not cleared.
// ----------------------------------------------------------------------------
// radix2_fft_inplace: in-place radix-2 decimation-in-time complex FFT
// Stores Q15 samples, runs a forward or inverse transform over 2^L points and
// returns bins on request.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_fft_inplace #(
    parameter int MAX_POINTS  = fftr_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = fftr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Request channel.
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [fftr_pkg::REQ_W-1:0]             s_req_type,
    input  wire logic [fftr_pkg::INDEX_W-1:0]           s_index,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample_real,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample_imag,
    // Result channel.
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [fftr_pkg::WORD_W-1:0]          m_out_real,
    output logic signed [fftr_pkg::WORD_W-1:0]          m_out_imag,
    output logic                                        m_status,
    // Configuration write channel.
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [fftr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [fftr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int WORD_W    = fftr_pkg::WORD_W;
    localparam int MEM_W     = 2 * WORD_W;
    localparam int ADDR_W    = $clog2(MAX_POINTS);
    localparam int IDX_EXT_W = (ADDR_W > fftr_pkg::INDEX_W) ? ADDR_W : fftr_pkg::INDEX_W;
    localparam int ROM_AW    = $clog2(MAX_POINTS / 4 + 1);
    localparam int LOG2_W    = fftr_pkg::LOG2_W;

    localparam logic [LOG2_W-1:0] ADDR_W_L   = LOG2_W'(ADDR_W);
    localparam logic [ADDR_W-1:0] QUARTER_A  = ADDR_W'(MAX_POINTS / 4);
    localparam logic [ADDR_W-1:0] HALF_A     = ADDR_W'(MAX_POINTS / 2);

    // One-hot sequencer states.
    typedef enum logic [14:0] {
        ST_IDLE    = 15'h0001,
        ST_RD_WAIT = 15'h0002,
        ST_BR_CHK  = 15'h0004,
        ST_BR_RDB  = 15'h0008,
        ST_BR_WA   = 15'h0010,
        ST_BR_WB   = 15'h0020,
        ST_BF_RA   = 15'h0040,
        ST_BF_RB   = 15'h0080,
        ST_BF_MUL  = 15'h0100,
        ST_BF_SUM  = 15'h0200,
        ST_BF_WA   = 15'h0400,
        ST_BF_WB   = 15'h0800,
        ST_SC_RD   = 15'h1000,
        ST_SC_WR   = 15'h2000,
        ST_FIN     = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [LOG2_W-1:0] log2_length_reg;
    logic              inverse_mode_reg;

    // Sequencer counters and the length and mode latched for a run.
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-2:0] t_reg, t_next;
    logic [LOG2_W-1:0] s_reg, s_next;
    logic [LOG2_W-1:0] run_l_reg, run_l_next;
    logic              run_inv_reg, run_inv_next;

    // Result register.
    logic                     m_valid_reg, m_valid_next;
    logic signed [WORD_W-1:0] m_real_reg, m_imag_reg;
    logic                     m_status_reg;
    logic                     out_load;
    logic signed [WORD_W-1:0] out_real_val, out_imag_val;
    logic                     out_status_val;

    // Datapath registers.
    logic [MEM_W-1:0]         tmp_reg;
    logic [MEM_W-1:0]         ua_reg;
    logic signed [44:0]       p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [30:0]       vr_reg, vi_reg;

    // Sample memory: real part in the upper half of a word, imaginary below.
    logic [MEM_W-1:0]  mem [MAX_POINTS];
    logic [MEM_W-1:0]  mem_rdata_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [MEM_W-1:0]  mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    logic s_fire;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid    = m_valid_reg;
    assign m_out_real = m_real_reg;
    assign m_out_imag = m_imag_reg;
    assign m_status   = m_status_reg;

    // Length limited to the memory size; an index is in range when no bit at or
    // above position L is set.
    logic [LOG2_W-1:0]    l_eff;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 idx_ok;
    logic [ADDR_W-1:0]    idx_addr;

    assign l_eff    = (log2_length_reg > ADDR_W_L) ? ADDR_W_L : log2_length_reg;
    assign idx_ext  = IDX_EXT_W'(s_index);
    assign idx_ok   = ((idx_ext >> l_eff) == '0);
    assign idx_addr = idx_ext[ADDR_W-1:0];

    // Sign-extended sample as stored.
    logic signed [WORD_W-1:0] samp_r, samp_i;
    assign samp_r = WORD_W'(s_sample_real);
    assign samp_i = WORD_W'(s_sample_imag);

    // Index arithmetic for the latched run length.
    logic [ADDR_W-1:0] n_m1;
    logic [ADDR_W-1:0] half_last;
    logic [ADDR_W-1:0] rev_full;
    logic [ADDR_W-1:0] rev_i;
    logic              i_last;
    logic              t_last;

    assign n_m1      = ~({ADDR_W{1'b1}} << run_l_reg);
    assign half_last = n_m1 >> 1;
    assign i_last    = (i_reg == n_m1);
    assign t_last    = (ADDR_W'(t_reg) == half_last);

    always_comb begin
        for (int b = 0; b < ADDR_W; b++) begin
            rev_full[b] = i_reg[ADDR_W-1-b];
        end
    end
    assign rev_i = rev_full >> (ADDR_W_L - run_l_reg);

    // Butterfly addresses: a has a zero inserted at bit s-1 of t, b has it set.
    logic [ADDR_W-1:0] t_ext, half_mask, j_val, addr_a, addr_b, tw_k;
    logic [LOG2_W-1:0] s_m1;

    assign s_m1      = s_reg - LOG2_W'(1);
    assign t_ext     = ADDR_W'(t_reg);
    assign half_mask = ~({ADDR_W{1'b1}} << s_m1);
    assign j_val     = t_ext & half_mask;
    assign addr_a    = ((t_ext >> s_m1) << s_reg) | j_val;
    assign addr_b    = addr_a | (ADDR_W'(1) << s_m1);
    assign tw_k      = j_val << (ADDR_W_L - s_reg);

    // Twiddle lookup. Past a quarter turn the cosine is mirrored and negated.
    logic                      tw_neg;
    logic [ADDR_W-1:0]         tw_ac, tw_as;
    logic [fftr_pkg::TW_W-1:0] rom_c, rom_s;

    assign tw_neg = (tw_k > QUARTER_A);
    assign tw_ac  = tw_neg ? (HALF_A - tw_k) : tw_k;
    assign tw_as  = tw_neg ? (tw_k - QUARTER_A) : (QUARTER_A - tw_k);

    fftr_twiddle_rom #(
        .MAX_POINTS (MAX_POINTS)
    ) u_rom (
        .aclk   (aclk),
        .addr_c (tw_ac[ROM_AW-1:0]),
        .addr_s (tw_as[ROM_AW-1:0]),
        .data_c (rom_c),
        .data_s (rom_s)
    );

    // The ROM output is registered and belongs to the current butterfly by ST_BF_MUL,
    // where it is used, and the sign decision still sees the same angle.
    logic signed [17:0] c_s, s_s, w_r, w_i;
    assign c_s = signed'({1'b0, rom_c});
    assign s_s = signed'({1'b0, rom_s});
    assign w_r = tw_neg ? -c_s : c_s;
    assign w_i = run_inv_reg ? s_s : -s_s;

    logic signed [WORD_W-1:0] b_re, b_im, a_re, a_im;
    assign b_re = mem_rdata_reg[MEM_W-1:WORD_W];
    assign b_im = mem_rdata_reg[WORD_W-1:0];
    assign a_re = ua_reg[MEM_W-1:WORD_W];
    assign a_im = ua_reg[WORD_W-1:0];

    logic signed [45:0] sum_r, sum_i;
    assign sum_r = 46'(p_rr_reg) - 46'(p_ii_reg) + 46'sd16384;
    assign sum_i = 46'(p_ri_reg) + 46'(p_ir_reg) + 46'sd16384;

    logic signed [WORD_W-1:0] bf_a_re, bf_a_im, bf_b_re, bf_b_im;
    assign bf_a_re = fftr_pkg::sat_word(32'(a_re) + 32'(vr_reg));
    assign bf_a_im = fftr_pkg::sat_word(32'(a_im) + 32'(vi_reg));
    assign bf_b_re = fftr_pkg::sat_word(32'(a_re) - 32'(vr_reg));
    assign bf_b_im = fftr_pkg::sat_word(32'(a_im) - 32'(vi_reg));

    // Inverse scaling: round half up, then arithmetic shift by L.
    logic signed [31:0]       sc_bias;
    logic signed [WORD_W-1:0] sc_re, sc_im;
    assign sc_bias = 32'sd1 <<< s_m1;
    assign sc_re   = fftr_pkg::sat_word((32'(b_re) + sc_bias) >>> run_l_reg);
    assign sc_im   = fftr_pkg::sat_word((32'(b_im) + sc_bias) >>> run_l_reg);

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        run_l_next     = run_l_reg;
        run_inv_next   = run_inv_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = i_reg;
        mem_raddr      = i_reg;
        mem_wdata      = mem_rdata_reg;
        out_load       = 1'b0;
        out_real_val   = '0;
        out_imag_val   = '0;
        out_status_val = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (fftr_pkg::req_t'(s_req_type))
                        fftr_pkg::REQ_WRITE: begin
                            mem_we         = idx_ok;
                            mem_waddr      = idx_addr;
                            mem_wdata      = {samp_r, samp_i};
                            out_load       = 1'b1;
                            out_status_val = !idx_ok;
                        end
                        fftr_pkg::REQ_READ: begin
                            if (idx_ok) begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_addr;
                                state_next = ST_RD_WAIT;
                            end else begin
                                out_load       = 1'b1;
                                out_status_val = 1'b1;
                            end
                        end
                        fftr_pkg::REQ_RUN: begin
                            run_l_next   = l_eff;
                            run_inv_next = inverse_mode_reg;
                            // The scaling bias reads s, which reaches L at the end of the butterfly stages.
                            i_next       = '0;
                            state_next   = ST_BR_CHK;
                        end
                        fftr_pkg::REQ_NOP: begin
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            ST_RD_WAIT: begin
                out_load     = 1'b1;
                out_real_val = b_re;
                out_imag_val = b_im;
                state_next   = ST_IDLE;
            end

            ST_BR_CHK: begin
                if (i_reg < rev_i) begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_reg;
                    state_next = ST_BR_RDB;
                end else if (i_last) begin
                    s_next     = LOG2_W'(1);
                    t_next     = '0;
                    state_next = (run_l_reg == '0) ? ST_FIN : ST_BF_RA;
                end else begin
                    i_next = i_reg + ADDR_W'(1);
                end
            end

            ST_BR_RDB: begin
                mem_re     = 1'b1;
                mem_raddr  = rev_i;
                state_next = ST_BR_WA;
            end

            ST_BR_WA: begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = mem_rdata_reg;
                state_next = ST_BR_WB;
            end

            ST_BR_WB: begin
                mem_we    = 1'b1;
                mem_waddr = rev_i;
                mem_wdata = tmp_reg;
                if (i_last) begin
                    s_next     = LOG2_W'(1);
                    t_next     = '0;
                    state_next = ST_BF_RA;
                end else begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = ST_BR_CHK;
                end
            end

            ST_BF_RA: begin
                mem_re     = 1'b1;
                mem_raddr  = addr_a;
                state_next = ST_BF_RB;
            end

            ST_BF_RB: begin
                mem_re     = 1'b1;
                mem_raddr  = addr_b;
                state_next = ST_BF_MUL;
            end

            ST_BF_MUL: begin
                state_next = ST_BF_SUM;
            end

            ST_BF_SUM: begin
                state_next = ST_BF_WA;
            end

            ST_BF_WA: begin
                mem_we     = 1'b1;
                mem_waddr  = addr_a;
                mem_wdata  = {bf_a_re, bf_a_im};
                state_next = ST_BF_WB;
            end

            ST_BF_WB: begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = {bf_b_re, bf_b_im};
                if (!t_last) begin
                    t_next     = t_reg + (ADDR_W-1)'(1);
                    state_next = ST_BF_RA;
                end else if (s_reg != run_l_reg) begin
                    t_next     = '0;
                    s_next     = s_reg + LOG2_W'(1);
                    state_next = ST_BF_RA;
                end else if (run_inv_reg) begin
                    // s now equals L, so s-1 gives the rounding bias position.
                    i_next     = '0;
                    state_next = ST_SC_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_SC_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = ST_SC_WR;
            end

            ST_SC_WR: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = {sc_re, sc_im};
                if (i_last) begin
                    state_next = ST_FIN;
                end else begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = ST_SC_RD;
                end
            end

            ST_FIN: begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register drains on a completed result transaction and loads
    // when a result is ready; a load is only issued while it is free.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            i_reg            <= '0;
            t_reg            <= '0;
            s_reg            <= '0;
            run_l_reg        <= '0;
            run_inv_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            log2_length_reg  <= fftr_pkg::LOG2_LENGTH_RST;
            inverse_mode_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            t_reg       <= t_next;
            s_reg       <= s_next;
            run_l_reg   <= run_l_next;
            run_inv_reg <= run_inv_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fftr_pkg::CFG_LOG2_LENGTH) begin
                    log2_length_reg <= cfg_data[LOG2_W-1:0];
                end else if (cfg_index == fftr_pkg::CFG_INVERSE_MODE) begin
                    inverse_mode_reg <= cfg_data[0];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_real_reg   <= out_real_val;
            m_imag_reg   <= out_imag_val;
            m_status_reg <= out_status_val;
        end
        if (state_reg == ST_BR_RDB) begin
            tmp_reg <= mem_rdata_reg;
        end
        if (state_reg == ST_BF_RB) begin
            ua_reg <= mem_rdata_reg;
        end
        if (state_reg == ST_BF_MUL) begin
            p_rr_reg <= b_re * w_r;
            p_ii_reg <= b_im * w_i;
            p_ri_reg <= b_re * w_i;
            p_ir_reg <= b_im * w_r;
        end
        if (state_reg == ST_BF_SUM) begin
            vr_reg <= sum_r[45:15];
            vi_reg <= sum_i[45:15];
        end
    end

endmodule

`default_nettype wire

FILE: src/fftr_twiddle_rom.sv
// ----------------------------------------------------------------------------
// fftr_twiddle_rom: quarter-wave cosine table
// Holds cos(2*pi*k/MAX_POINTS) for k = 0..MAX_POINTS/4 in Q15 and returns
// two registered entries per cycle, one for the cosine and one for the sine.
// ----------------------------------------------------------------------------
`default_nettype none

module fftr_twiddle_rom #(
    parameter int MAX_POINTS = fftr_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic [$clog2(MAX_POINTS/4+1)-1:0]    addr_c,
    input  wire logic [$clog2(MAX_POINTS/4+1)-1:0]    addr_s,
    output logic      [fftr_pkg::TW_W-1:0]            data_c,
    output logic      [fftr_pkg::TW_W-1:0]            data_s
);

    localparam int QUARTER = MAX_POINTS / 4;

    logic [fftr_pkg::TW_W-1:0] rom_tab [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        localparam longint THETA = longint'(g) * fftr_pkg::TWO_PI_Q30 / MAX_POINTS;
        localparam logic [fftr_pkg::TW_W-1:0] COS_VAL = fftr_pkg::cos_q15(THETA);
        assign rom_tab[g] = COS_VAL;
    end

    always_ff @(posedge aclk) begin
        data_c <= rom_tab[addr_c];
        data_s <= rom_tab[addr_s];
    end

endmodule

`default_nettype wire

FILE: tb/sv/radix2_fft_inplace_tb.sv
// ----------------------------------------------------------------------------
// radix2_fft_inplace_tb: self-checking bench for the in-place radix-2 FFT
// Loads sample frames, runs forward and inverse transforms at many lengths,
// reads bins back and compares every result against an in-bench
// fixed-point FFT predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_fft_inplace_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WORD_W     = fftr_pkg::WORD_W;
    localparam int  INDEX_W    = fftr_pkg::INDEX_W;
    localparam int  CFG_DATA_W = fftr_pkg::CFG_DATA_W;
    localparam int  NPTS       = 1024;
    localparam int  QUART      = NPTS / 4;
    localparam int  HANG_LIMIT = 200000;
    localparam int  RAND_ITEMS = 700;
    localparam longint W_MAX   = 67108863;
    localparam longint W_MIN   = -67108864;

    // One expected result as it should appear on the m_ channel.
    typedef struct {
        logic signed [WORD_W-1:0] re;
        logic signed [WORD_W-1:0] im;
        logic                     st;
    } bin_result_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [fftr_pkg::REQ_W-1:0]           s_req_type;
    logic [INDEX_W-1:0]                   s_index;
    logic signed [15:0]                   s_sample_real;
    logic signed [15:0]                   s_sample_imag;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [WORD_W-1:0]             m_out_real;
    logic signed [WORD_W-1:0]             m_out_imag;
    logic                                 m_status;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [fftr_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]                cfg_data;

    // Predictor state: the sample/bin store, the register copies and the
    // quarter-wave cosine table.
    longint      bin_re [NPTS];
    longint      bin_im [NPTS];
    int          cos_tab [QUART+1];
    logic [3:0]  len_log2;
    logic        inv_sel;

    bin_result_t pending_bins [$];
    int          error_count;
    int          items_sent;
    int          idle_cycles;
    int          rx_stall;
    bit          no_gaps;

    radix2_fft_inplace dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_index       (s_index),
        .s_sample_real (s_sample_real),
        .s_sample_imag (s_sample_imag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_real    (m_out_real),
        .m_out_imag    (m_out_imag),
        .m_status      (m_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Cosine table in Q15, evaluated by a Q30 Taylor series and rounded to
    // nearest, so that it matches the hardware ROM exactly.
    task automatic build_cos_table();
        longint          ang;
        longint unsigned sq;
        longint unsigned t;
        longint          acc;
        longint          q;
        for (int k = 0; k <= QUART; k++) begin
            ang = longint'(k) * fftr_pkg::TWO_PI_Q30 / NPTS;
            sq  = (unsigned'(ang) * unsigned'(ang)) >> 30;
            acc = 64'sd1 <<< 30;
            t   = 64'd1 << 30;
            for (int m = 1; m <= 16; m++) begin
                t = ((t * sq) >> 30) / unsigned'(64'((2 * m - 1) * (2 * m)));
                if (m % 2 == 1) begin
                    acc = acc - longint'(t);
                end else begin
                    acc = acc + longint'(t);
                end
            end
            q = (acc + 16384) >>> 15;
            if (q < 0) q = 0;
            if (q > 32768) q = 32768;
            cos_tab[k] = int'(q);
        end
    endtask

    function automatic longint clamp27(input longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    // Lengths above the memory size saturate to the full 1024 points.
    function automatic int eff_log2();
        return (len_log2 > 10) ? 10 : int'(len_log2);
    endfunction

    // Bit reversal, then every butterfly stage, then the 1/n scaling of the
    // inverse transform with round-half-up.
    task automatic compute_fft();
        int     lg, n, r, half, stride, k, a, b;
        longint t, c, s, wr, wi, br, bi, vr, vi, ur, ui;
        lg = eff_log2();
        n  = 1 << lg;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int bb = 0; bb < lg; bb++) r |= ((i >> bb) & 1) << (lg - 1 - bb);
            if (i < r) begin
                t = bin_re[i]; bin_re[i] = bin_re[r]; bin_re[r] = t;
                t = bin_im[i]; bin_im[i] = bin_im[r]; bin_im[r] = t;
            end
        end
        for (int sz = 2; sz <= n; sz = sz << 1) begin
            half   = sz >> 1;
            stride = NPTS / sz;
            for (int st = 0; st < n; st += sz) begin
                for (int j = 0; j < half; j++) begin
                    k = j * stride;
                    if (k <= QUART) begin
                        c = cos_tab[k];
                        s = cos_tab[QUART - k];
                    end else begin
                        c = -longint'(cos_tab[NPTS / 2 - k]);
                        s = cos_tab[k - QUART];
                    end
                    wr = c;
                    wi = inv_sel ? s : -s;
                    a  = st + j;
                    b  = a + half;
                    br = bin_re[b];
                    bi = bin_im[b];
                    vr = (br * wr - bi * wi + 16384) >>> 15;
                    vi = (br * wi + bi * wr + 16384) >>> 15;
                    ur = bin_re[a];
                    ui = bin_im[a];
                    bin_re[a] = clamp27(ur + vr);
                    bin_im[a] = clamp27(ui + vi);
                    bin_re[b] = clamp27(ur - vr);
                    bin_im[b] = clamp27(ui - vi);
                end
            end
        end
        if (inv_sel && lg > 0) begin
            for (int i = 0; i < n; i++) begin
                bin_re[i] = clamp27((bin_re[i] + (64'sd1 <<< (lg - 1))) >>> lg);
                bin_im[i] = clamp27((bin_im[i] + (64'sd1 <<< (lg - 1))) >>> lg);
            end
        end
    endtask

    // Presents one request, waits for the handshake and records the result
    // that the request must produce. Called and returns at a rising edge.
    task automatic send_req(input fftr_pkg::req_t rt, input logic [INDEX_W-1:0] idx,
                            input logic signed [15:0] re, input logic signed [15:0] im);
        int          gap;
        int          n;
        bin_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= rt;
        s_index       <= idx;
        s_sample_real <= re;
        s_sample_imag <= im;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n   = 1 << eff_log2();
        res = '{re: '0, im: '0, st: 1'b0};
        case (rt)
            fftr_pkg::REQ_WRITE: begin
                if (idx < n) begin
                    bin_re[idx] = re;
                    bin_im[idx] = im;
                end else begin
                    res.st = 1'b1;
                end
            end
            fftr_pkg::REQ_RUN: begin
                compute_fft();
            end
            fftr_pkg::REQ_READ: begin
                if (idx < n) begin
                    res.re = bin_re[idx][WORD_W-1:0];
                    res.im = bin_im[idx][WORD_W-1:0];
                end else begin
                    res.st = 1'b1;
                end
            end
            default: begin
            end
        endcase
        pending_bins.push_back(res);
        items_sent++;
    endtask

    // Holds the sender until every outstanding result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input fftr_pkg::cfg_idx_t ri,
                             input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (ri == fftr_pkg::CFG_LOG2_LENGTH) begin
            len_log2 = val;
        end else begin
            inv_sel = val[0];
        end
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_frame();
        for (int i = 0; i < (1 << eff_log2()); i++) begin
            send_req(fftr_pkg::REQ_WRITE, INDEX_W'(i), rand_sample(), rand_sample());
        end
    endtask

    // Four-point frame of full-scale values, every request type, the
    // out-of-range cases of write and read and a no-op with busy fields.
    task automatic test_directed_small();
        write_reg(fftr_pkg::CFG_INVERSE_MODE, 4'd0);
        write_reg(fftr_pkg::CFG_LOG2_LENGTH, 4'd2);
        send_req(fftr_pkg::REQ_WRITE, 10'd0, 16'sh7FFF, 16'sh8000);
        send_req(fftr_pkg::REQ_WRITE, 10'd1, 16'sh8000, 16'sh7FFF);
        send_req(fftr_pkg::REQ_WRITE, 10'd2, 16'sh7FFF, 16'sh7FFF);
        send_req(fftr_pkg::REQ_WRITE, 10'd3, 16'sh8000, 16'sh8000);
        send_req(fftr_pkg::REQ_WRITE, 10'd4, 16'sh1234, 16'sh4321);
        send_req(fftr_pkg::REQ_WRITE, 10'h3FF, 16'shFFFF, 16'shFFFF);
        send_req(fftr_pkg::REQ_READ, 10'd3, 16'shFFFF, 16'sh0000);
        send_req(fftr_pkg::REQ_RUN, 10'h3FF, 16'shFFFF, 16'shFFFF);
        for (int i = 0; i < 4; i++) send_req(fftr_pkg::REQ_READ, INDEX_W'(i), '0, '0);
        send_req(fftr_pkg::REQ_READ, 10'h3FF, '0, '0);
        send_req(fftr_pkg::REQ_READ, 10'd4, '0, '0);
        send_req(fftr_pkg::REQ_NOP, 10'h2AA, 16'sh5555, 16'shAAAA);
    endtask

    // A single point passes through unchanged in both directions.
    task automatic test_identity();
        for (int m = 0; m < 2; m++) begin
            write_reg(fftr_pkg::CFG_INVERSE_MODE, 4'(m));
            write_reg(fftr_pkg::CFG_LOG2_LENGTH, 4'd0);
            send_req(fftr_pkg::REQ_WRITE, 10'd0, 16'sh8000, 16'sh7FFF);
            send_req(fftr_pkg::REQ_WRITE, 10'd1, 16'sh0001, 16'sh0001);
            send_req(fftr_pkg::REQ_RUN, '0, '0, '0);
            send_req(fftr_pkg::REQ_READ, 10'd0, '0, '0);
        end
    endtask

    // A length code above the limit acts as the full 1024 points, so the
    // top indices are accepted and read back.
    task automatic test_length_limit();
        write_reg(fftr_pkg::CFG_LOG2_LENGTH, 4'd15);
        send_req(fftr_pkg::REQ_WRITE, 10'h3FF, 16'sh7FFF, 16'sh8000);
        send_req(fftr_pkg::REQ_WRITE, 10'd700, 16'sh1357, 16'shECA8);
        send_req(fftr_pkg::REQ_READ, 10'h3FF, '0, '0);
        send_req(fftr_pkg::REQ_READ, 10'd700, '0, '0);
    endtask

    // A 64-point frame run four times without reloading drives the words
    // into saturation; an inverse run over the result follows.
    task automatic test_saturation();
        write_reg(fftr_pkg::CFG_INVERSE_MODE, 4'd0);
        write_reg(fftr_pkg::CFG_LOG2_LENGTH, 4'd6);
        load_frame();
        for (int r = 0; r < 4; r++) begin
            send_req(fftr_pkg::REQ_RUN, 10'($urandom), '0, '0);
            for (int i = 0; i < 6; i++) begin
                send_req(fftr_pkg::REQ_READ, INDEX_W'($urandom_range(0, 63)), '0, '0);
            end
        end
        write_reg(fftr_pkg::CFG_INVERSE_MODE, 4'd1);
        send_req(fftr_pkg::REQ_RUN, '0, '0, '0);
        for (int i = 0; i < 6; i++) begin
            send_req(fftr_pkg::REQ_READ, INDEX_W'($urandom_range(0, 63)), '0, '0);
        end
    endtask

    // Random phases: a fresh setting, a full frame, then a mix of runs and
    // reads with some noise. Most lengths stay small to keep runs short.
    task automatic test_random_frames();
        int sel, ops, n, ri;
        logic [3:0] lg;
        while (items_sent < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            lg  = (sel < 80) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(6, 7));
            write_reg(fftr_pkg::CFG_LOG2_LENGTH, lg);
            write_reg(fftr_pkg::CFG_INVERSE_MODE, 4'($urandom_range(0, 1)));
            no_gaps = ($urandom_range(0, 4) == 0);
            load_frame();
            n   = 1 << eff_log2();
            ops = $urandom_range(4, 16);
            for (int i = 0; i < ops; i++) begin
                sel = $urandom_range(0, 99);
                ri  = $urandom_range(0, n - 1);
                if (sel < 15) begin
                    send_req(fftr_pkg::REQ_RUN, 10'($urandom), 16'($urandom),
                             16'($urandom));
                end else if (sel < 65) begin
                    send_req(fftr_pkg::REQ_READ, INDEX_W'(ri), 16'($urandom),
                             16'($urandom));
                end else if (sel < 75) begin
                    send_req(fftr_pkg::REQ_WRITE, INDEX_W'(ri), rand_sample(),
                             rand_sample());
                end else if (sel < 85) begin
                    send_req(fftr_pkg::REQ_READ,
                             INDEX_W'($urandom_range(n, NPTS - 1 + n) % NPTS), '0, '0);
                end else if (sel < 92) begin
                    send_req(fftr_pkg::REQ_WRITE, 10'($urandom), rand_sample(),
                             rand_sample());
                end else begin
                    send_req(fftr_pkg::REQ_NOP, 10'($urandom), 16'($urandom),
                             16'($urandom));
                end
            end
            if ($urandom_range(0, 3) == 0) drain();
            send_req(fftr_pkg::REQ_RUN, '0, '0, '0);
            for (int i = 0; i < 4; i++) begin
                send_req(fftr_pkg::REQ_READ, INDEX_W'($urandom_range(0, n - 1)), '0, '0);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result checker and receiver stall generator. Outputs are sampled at
    // the edge, before this step's nonblocking updates land.
    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bins.size() == 0) begin
                $display("%0t ERROR unexpected result: real %0d imag %0d status %0d",
                         $time, m_out_real, m_out_imag, m_status);
                error_count++;
            end else begin
                want = pending_bins.pop_front();
                if (m_out_real !== want.re) begin
                    $display("%0t ERROR out_real: expected %0d actual %0d",
                             $time, want.re, m_out_real);
                    error_count++;
                end
                if (m_out_imag !== want.im) begin
                    $display("%0t ERROR out_imag: expected %0d actual %0d",
                             $time, want.im, m_out_imag);
                    error_count++;
                end
                if (m_status !== want.st) begin
                    $display("%0t ERROR status: expected %0d actual %0d",
                             $time, want.st, m_status);
                    error_count++;
                end
            end
        end
        if (rx_stall > 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall <= pick_gap();
        end
    end

    // Watchdog: a stretch with no transaction on any channel ends the run.
    // The limit covers the longest inverse run at 128 points many times over.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= fftr_pkg::REQ_NOP;
        s_index       <= '0;
        s_sample_real <= '0;
        s_sample_imag <= '0;
        m_ready       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= fftr_pkg::CFG_LOG2_LENGTH;
        cfg_data      <= '0;
        error_count   = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        rx_stall      = 0;
        no_gaps       = 1'b0;
        len_log2      = fftr_pkg::LOG2_LENGTH_RST;
        inv_sel       = 1'b0;
        for (int i = 0; i < NPTS; i++) begin
            bin_re[i] = 0;
            bin_im[i] = 0;
        end
        build_cos_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_small();
        test_identity();
        test_length_limit();
        test_saturation();
        test_random_frames();

        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
